### rtl/qeo_pkg.sv
// Shared constants for the quadrilateral edge offset unit.
`timescale 1ns / 1ps
package qeo_pkg;

  // Default coordinate width (two's complement, fixed point).
  localparam int COORD_WIDTH_DEF = 24;

  // Intersection quotients clamp to +/- 2**QLIM_LOG before the final add.
  localparam int QLIM_LOG = 40;

endpackage

### rtl/qeo_sqrt.sv
// Pipelined integer square root, one root bit per stage.
`timescale 1ns / 1ps
module qeo_sqrt #(
  parameter int RTW = 25,
  parameter int SW  = 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  logic [2*RTW-1:0]     rad_i,
  input  logic [SW-1:0]        side_i,
  output logic                 valid_o,
  output logic [RTW-1:0]       root_o,
  output logic [SW-1:0]        side_o
);

  localparam int RMW = RTW + 2;

  logic [RTW:0]       vld_q;
  logic [2*RTW-1:0]   rad_q  [RTW+1];
  logic [RMW-1:0]     rem_q  [RTW+1];
  logic [RTW-1:0]     root_q [RTW+1];
  logic [SW-1:0]      side_q [RTW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[RTW-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q[0]  <= rad_i;
    rem_q[0]  <= '0;
    root_q[0] <= '0;
    side_q[0] <= side_i;
  end

  for (genvar i = 0; i < RTW; i++) begin : g_stage
    logic [RMW+1:0] trial;
    logic [RMW+1:0] part;
    logic           ge;

    // Bring down the next two radicand bits and test root*4+1.
    assign part  = {rem_q[i], rad_q[i][2*RTW-1 -: 2]};
    assign trial = (RMW+2)'({root_q[i], 2'b01});
    assign ge    = part >= trial;

    always_ff @(posedge clk_i) begin
      rad_q[i+1]  <= rad_q[i] << 2;
      rem_q[i+1]  <= ge ? RMW'(part - trial) : RMW'(part);
      root_q[i+1] <= {root_q[i][RTW-2:0], ge};
      side_q[i+1] <= side_q[i];
    end
  end

  assign valid_o = vld_q[RTW];
  assign root_o  = root_q[RTW];
  assign side_o  = side_q[RTW];

endmodule

### rtl/qeo_div.sv
// Pipelined unsigned restoring divider with round-half-up and overflow flag.
`timescale 1ns / 1ps
module qeo_div #(
  parameter int NW = 48,
  parameter int DW = 25,
  parameter int QW = 24,
  parameter int SW = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic [NW-1:0]     num_i,
  input  logic [DW-1:0]     den_i,
  input  logic [SW-1:0]     side_i,
  output logic              valid_o,
  output logic [QW:0]       quo_o,
  output logic              ovf_o,
  output logic [SW-1:0]     side_o
);

  localparam int XW = NW + DW;

  logic [QW+1:0]     vld_q;
  logic [DW-1:0]     rem_q  [QW+1];
  logic [QW-1:0]     low_q  [QW+1];
  logic [QW-1:0]     quo_q  [QW+1];
  logic [DW-1:0]     den_q  [QW+1];
  logic [QW:0]       ovf_q;
  logic [SW-1:0]     side_q [QW+1];
  logic [XW-1:0]     top_w;
  logic              up_w;

  // Quotient fits in QW bits only when the upper dividend part is below the divisor.
  assign top_w = XW'(num_i) >> QW;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[QW:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q[0]  <= DW'(top_w);
    low_q[0]  <= num_i[QW-1:0];
    quo_q[0]  <= '0;
    den_q[0]  <= den_i;
    ovf_q[0]  <= top_w >= XW'(den_i);
    side_q[0] <= side_i;
  end

  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic [DW:0] part;
    logic        ge;

    assign part = {rem_q[i], low_q[i][QW-1]};
    assign ge   = part >= {1'b0, den_q[i]};

    always_ff @(posedge clk_i) begin
      rem_q[i+1]  <= ge ? DW'(part - {1'b0, den_q[i]}) : DW'(part);
      low_q[i+1]  <= low_q[i] << 1;
      quo_q[i+1]  <= {quo_q[i][QW-2:0], ge};
      den_q[i+1]  <= den_q[i];
      ovf_q[i+1]  <= ovf_q[i];
      side_q[i+1] <= side_q[i];
    end
  end

  // Round half away from zero on the magnitude: bump when 2*rem >= den.
  assign up_w = {rem_q[QW], 1'b0} >= {1'b0, den_q[QW]};

  always_ff @(posedge clk_i) begin
    quo_o  <= {1'b0, quo_q[QW]} + (QW+1)'(up_w);
    ovf_o  <= ovf_q[QW];
    side_o <= side_q[QW];
  end

  assign valid_o = vld_q[QW+1];

endmodule

### rtl/qeo_edge.sv
// One edge: direction, length, scaled normal and shifted start point.
`timescale 1ns / 1ps
module qeo_edge import qeo_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  logic signed [COORD_WIDTH-1:0] p0x_i,
  input  logic signed [COORD_WIDTH-1:0] p0y_i,
  input  logic signed [COORD_WIDTH-1:0] p1x_i,
  input  logic signed [COORD_WIDTH-1:0] p1y_i,
  input  logic signed [COORD_WIDTH-1:0] dist_i,
  output logic                          valid_o,
  output logic signed [COORD_WIDTH+1:0] bx_o,
  output logic signed [COORD_WIDTH+1:0] by_o,
  output logic signed [COORD_WIDTH:0]   dx_o,
  output logic signed [COORD_WIDTH:0]   dy_o
);

  localparam int W   = COORD_WIDTH;
  localparam int DXW = W + 1;
  localparam int PW  = 2 * DXW;
  localparam int MXW = DXW + W;
  localparam int MW  = 2 * W - 1;
  localparam int RTW = W + 1;
  localparam int BW  = W + 2;

  typedef struct packed {
    logic signed [W-1:0]   px;
    logic signed [W-1:0]   py;
    logic signed [DXW-1:0] dx;
    logic signed [DXW-1:0] dy;
    logic [MW-1:0]         mxm;
    logic [MW-1:0]         mym;
    logic                  sx;
    logic                  sy;
  } sq_side_t;

  typedef struct packed {
    logic signed [W-1:0]   px;
    logic signed [DXW-1:0] dx;
    logic                  sx;
    logic                  zero;
  } dx_side_t;

  typedef struct packed {
    logic signed [W-1:0]   py;
    logic signed [DXW-1:0] dy;
    logic                  sy;
  } dy_side_t;

  logic                  vld1_q, vld2_q, vld3_q;
  logic signed [DXW-1:0] dx1_q, dy1_q, dx2_q, dy2_q;
  logic signed [W-1:0]   s1_q, px1_q, py1_q, px2_q, py2_q;
  logic signed [PW-1:0]  sqx2_q, sqy2_q;
  logic signed [MXW-1:0] mx2_q, my2_q, mxa_w, mya_w;
  logic [2*RTW-1:0]      rad3_q;
  sq_side_t              sq3_q, sq_out_w;
  logic                  sq_vld_w;
  logic [RTW-1:0]        len_w;
  dx_side_t              dxs_in_w, dxs_out_w;
  dy_side_t              dys_in_w, dys_out_w;
  logic                  dvx_vld_w, dvy_vld_w, ovfx_w, ovfy_w;
  logic [W:0]            qx_w, qy_w;
  logic signed [DXW-1:0] vx_w, vy_w;
  logic                  vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
      vld_q  <= 1'b0;
    end else begin
      vld1_q <= valid_i;
      vld2_q <= vld1_q;
      vld3_q <= vld2_q;
      vld_q  <= dvx_vld_w & dvy_vld_w;
    end
  end

  assign mxa_w = mx2_q[MXW-1] ? -mx2_q : mx2_q;
  assign mya_w = my2_q[MXW-1] ? -my2_q : my2_q;

  always_ff @(posedge clk_i) begin
    dx1_q  <= DXW'(p1x_i) - DXW'(p0x_i);
    dy1_q  <= DXW'(p1y_i) - DXW'(p0y_i);
    s1_q   <= dist_i;
    px1_q  <= p0x_i;
    py1_q  <= p0y_i;
    sqx2_q <= dx1_q * dx1_q;
    sqy2_q <= dy1_q * dy1_q;
    mx2_q  <= dx1_q * s1_q;
    my2_q  <= dy1_q * s1_q;
    dx2_q  <= dx1_q;
    dy2_q  <= dy1_q;
    px2_q  <= px1_q;
    py2_q  <= py1_q;
    rad3_q <= (2*RTW)'($unsigned(sqx2_q)) + (2*RTW)'($unsigned(sqy2_q));
    sq3_q  <= '{px: px2_q, py: py2_q, dx: dx2_q, dy: dy2_q,
                mxm: mxa_w[MW-1:0], mym: mya_w[MW-1:0],
                sx: mx2_q[MXW-1], sy: my2_q[MXW-1]};
  end

  qeo_sqrt #(
    .RTW (RTW),
    .SW  ($bits(sq_side_t))
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vld3_q),
    .rad_i   (rad3_q),
    .side_i  (sq3_q),
    .valid_o (sq_vld_w),
    .root_o  (len_w),
    .side_o  (sq_out_w)
  );

  assign dxs_in_w = '{px: sq_out_w.px, dx: sq_out_w.dx, sx: sq_out_w.sx,
                      zero: len_w == '0};
  assign dys_in_w = '{py: sq_out_w.py, dy: sq_out_w.dy, sy: sq_out_w.sy};

  qeo_div #(
    .NW (MW),
    .DW (RTW),
    .QW (W),
    .SW ($bits(dx_side_t))
  ) u_div_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sq_vld_w),
    .num_i   (sq_out_w.mxm),
    .den_i   (len_w),
    .side_i  (dxs_in_w),
    .valid_o (dvx_vld_w),
    .quo_o   (qx_w),
    .ovf_o   (ovfx_w),
    .side_o  (dxs_out_w)
  );

  qeo_div #(
    .NW (MW),
    .DW (RTW),
    .QW (W),
    .SW ($bits(dy_side_t))
  ) u_div_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sq_vld_w),
    .num_i   (sq_out_w.mym),
    .den_i   (len_w),
    .side_i  (dys_in_w),
    .valid_o (dvy_vld_w),
    .quo_o   (qy_w),
    .ovf_o   (ovfy_w),
    .side_o  (dys_out_w)
  );

  // |d|/len <= 1, so the quotient never overflows; drop it on a zero-length edge.
  always_comb begin
    vx_w = dxs_out_w.sx ? -$signed(qx_w) : $signed(qx_w);
    vy_w = dys_out_w.sy ? -$signed(qy_w) : $signed(qy_w);
    if (dxs_out_w.zero || ovfx_w || ovfy_w) begin
      vx_w = '0;
      vy_w = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    bx_o <= BW'(dxs_out_w.px) + BW'(vy_w);
    by_o <= BW'(dys_out_w.py) - BW'(vx_w);
    dx_o <= dxs_out_w.dx;
    dy_o <= dys_out_w.dy;
  end

  assign valid_o = vld_q;

endmodule

### rtl/qeo_corner.sv
// One corner: intersection of the previous and the current shifted edge.
`timescale 1ns / 1ps
module qeo_corner import qeo_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  logic signed [COORD_WIDTH+1:0] bxp_i,
  input  logic signed [COORD_WIDTH+1:0] byp_i,
  input  logic signed [COORD_WIDTH:0]   dxp_i,
  input  logic signed [COORD_WIDTH:0]   dyp_i,
  input  logic signed [COORD_WIDTH+1:0] bxk_i,
  input  logic signed [COORD_WIDTH+1:0] byk_i,
  input  logic signed [COORD_WIDTH:0]   dxk_i,
  input  logic signed [COORD_WIDTH:0]   dyk_i,
  output logic                          valid_o,
  output logic signed [COORD_WIDTH-1:0] cx_o,
  output logic signed [COORD_WIDTH-1:0] cy_o,
  output logic                          degen_o
);

  localparam int W   = COORD_WIDTH;
  localparam int DXW = W + 1;
  localparam int BW  = W + 2;
  localparam int DFW = W + 3;
  localparam int PW  = DXW + DFW;
  localparam int AW  = PW + 1;
  localparam int AL  = W + 3;
  localparam int AH  = AW - AL;
  localparam int HW  = DXW + AH;
  localparam int LW  = DXW + AL + 1;
  localparam int DNW = AW + 1;
  localparam int NMW = 3 * W + 6;
  localparam int NW  = NMW - 1;
  localparam int QW  = QLIM_LOG + 1;
  localparam int QSW = QLIM_LOG + 2;
  localparam int SMW = ((BW > QSW) ? BW : QSW) + 1;

  localparam logic [QW:0]            QLIM = (QW+1)'(1) << QLIM_LOG;
  localparam logic signed [SMW-1:0]  MAXV = SMW'({(W-1){1'b1}});
  localparam logic signed [SMW-1:0]  MINV = ~MAXV;

  typedef struct packed {
    logic signed [BW-1:0] bxp;
    logic signed [BW-1:0] bxk;
    logic                 neg;
    logic                 zero;
  } cx_side_t;

  typedef struct packed {
    logic signed [BW-1:0] byp;
    logic signed [BW-1:0] byk;
    logic                 neg;
  } cy_side_t;

  logic [5:0]            vld_q;
  logic signed [DFW-1:0] e1_q, e2_q, f1_q, f2_q;
  logic signed [DXW-1:0] ux1_q, uy1_q, dxp1_q, dyp1_q, dxp2_q, dyp2_q, dxp3_q, dyp3_q;
  logic signed [BW-1:0]  bxp_q [5];
  logic signed [BW-1:0]  byp_q [5];
  logic signed [BW-1:0]  bxk_q [5];
  logic signed [BW-1:0]  byk_q [5];
  logic signed [PW-1:0]  p1_q, p2_q, p3_q, p4_q;
  logic signed [AW-1:0]  a3_q, b3_q;
  logic signed [DNW-1:0] den4_q, den5_q;
  logic signed [HW-1:0]  hx4_q, hy4_q;
  logic signed [LW-1:0]  lx4_q, ly4_q;
  logic signed [NMW-1:0] nx5_q, ny5_q, nxa_w, nya_w;
  logic signed [DNW-1:0] dna_w;
  logic [NW-1:0]         nmx6_q, nmy6_q;
  logic [DNW-1:0]        dm6_q;
  cx_side_t              cxs6_q, cxs_w;
  cy_side_t              cys6_q, cys_w;
  logic                  dvx_vld_w, dvy_vld_w, ovfx_w, ovfy_w;
  logic [QW:0]           qx_w, qy_w, mx_w, my_w;
  logic signed [QSW-1:0] qsx_w, qsy_w;
  logic signed [SMW-1:0] selx_w, sely_w;
  logic                  vld_q7;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      vld_q7 <= 1'b0;
    end else begin
      vld_q  <= {vld_q[4:0], valid_i};
      vld_q7 <= dvx_vld_w & dvy_vld_w;
    end
  end

  // Carry the shifted edge start points along the front stages.
  always_ff @(posedge clk_i) begin
    bxp_q[0] <= bxp_i;
    byp_q[0] <= byp_i;
    bxk_q[0] <= bxk_i;
    byk_q[0] <= byk_i;
    for (int i = 1; i < 5; i++) begin
      bxp_q[i] <= bxp_q[i-1];
      byp_q[i] <= byp_q[i-1];
      bxk_q[i] <= bxk_q[i-1];
      byk_q[i] <= byk_q[i-1];
    end
  end

  assign nxa_w = nx5_q[NMW-1] ? -nx5_q : nx5_q;
  assign nya_w = ny5_q[NMW-1] ? -ny5_q : ny5_q;
  assign dna_w = den5_q[DNW-1] ? -den5_q : den5_q;

  always_ff @(posedge clk_i) begin
    // Differences between the two shifted edges.
    e1_q   <= DFW'(byp_i) - DFW'(byk_i);
    e2_q   <= DFW'(bxp_i) - DFW'(bxk_i);
    f1_q   <= DFW'(byk_i) - DFW'(byp_i) - DFW'(dyp_i);
    f2_q   <= DFW'(bxk_i) - DFW'(bxp_i) - DFW'(dxp_i);
    ux1_q  <= dxk_i;
    uy1_q  <= dyk_i;
    dxp1_q <= dxp_i;
    dyp1_q <= dyp_i;
    // Cross products.
    p1_q   <= ux1_q * e1_q;
    p2_q   <= uy1_q * e2_q;
    p3_q   <= ux1_q * f1_q;
    p4_q   <= uy1_q * f2_q;
    dxp2_q <= dxp1_q;
    dyp2_q <= dyp1_q;
    a3_q   <= AW'(p1_q) - AW'(p2_q);
    b3_q   <= AW'(p3_q) - AW'(p4_q);
    dxp3_q <= dxp2_q;
    dyp3_q <= dyp2_q;
    // Numerator split into two partial products.
    den4_q <= DNW'(a3_q) + DNW'(b3_q);
    hx4_q  <= dxp3_q * $signed(a3_q[AW-1:AL]);
    hy4_q  <= dyp3_q * $signed(a3_q[AW-1:AL]);
    lx4_q  <= dxp3_q * $signed({1'b0, a3_q[AL-1:0]});
    ly4_q  <= dyp3_q * $signed({1'b0, a3_q[AL-1:0]});
    nx5_q  <= (NMW'(hx4_q) <<< AL) + NMW'(lx4_q);
    ny5_q  <= (NMW'(hy4_q) <<< AL) + NMW'(ly4_q);
    den5_q <= den4_q;
    // Sign and magnitude for the dividers.
    nmx6_q <= NW'(nxa_w);
    nmy6_q <= NW'(nya_w);
    dm6_q  <= $unsigned(dna_w);
    cxs6_q <= '{bxp: bxp_q[4], bxk: bxk_q[4], neg: nx5_q[NMW-1] ^ den5_q[DNW-1],
                zero: den5_q == '0};
    cys6_q <= '{byp: byp_q[4], byk: byk_q[4], neg: ny5_q[NMW-1] ^ den5_q[DNW-1]};
  end

  qeo_div #(
    .NW (NW),
    .DW (DNW),
    .QW (QW),
    .SW ($bits(cx_side_t))
  ) u_div_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vld_q[5]),
    .num_i   (nmx6_q),
    .den_i   (dm6_q),
    .side_i  (cxs6_q),
    .valid_o (dvx_vld_w),
    .quo_o   (qx_w),
    .ovf_o   (ovfx_w),
    .side_o  (cxs_w)
  );

  qeo_div #(
    .NW (NW),
    .DW (DNW),
    .QW (QW),
    .SW ($bits(cy_side_t))
  ) u_div_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vld_q[5]),
    .num_i   (nmy6_q),
    .den_i   (dm6_q),
    .side_i  (cys6_q),
    .valid_o (dvy_vld_w),
    .quo_o   (qy_w),
    .ovf_o   (ovfy_w),
    .side_o  (cys_w)
  );

  // Clamp, add to the previous edge start and saturate; pass the start through if degenerate.
  always_comb begin
    mx_w   = (ovfx_w || qx_w > QLIM) ? QLIM : qx_w;
    my_w   = (ovfy_w || qy_w > QLIM) ? QLIM : qy_w;
    qsx_w  = cxs_w.neg ? -$signed(QSW'(mx_w)) : $signed(QSW'(mx_w));
    qsy_w  = cys_w.neg ? -$signed(QSW'(my_w)) : $signed(QSW'(my_w));
    selx_w = SMW'(cxs_w.bxp) + SMW'(qsx_w);
    sely_w = SMW'(cys_w.byp) + SMW'(qsy_w);
    if (cxs_w.zero) begin
      selx_w = SMW'(cxs_w.bxk);
      sely_w = SMW'(cys_w.byk);
    end
  end

  always_ff @(posedge clk_i) begin
    cx_o    <= (selx_w > MAXV) ? W'(MAXV) : (selx_w < MINV) ? W'(MINV) : W'(selx_w);
    cy_o    <= (sely_w > MAXV) ? W'(MAXV) : (sely_w < MINV) ? W'(MINV) : W'(sely_w);
    degen_o <= cxs_w.zero;
  end

  assign valid_o = vld_q7;

endmodule

### rtl/quad_edge_offset_unit.sv
// Top level of the quadrilateral edge offset unit.
`timescale 1ns / 1ps
// Offsets a quadrilateral: every edge moves along its normal by the signed
// distance, and each new corner is where the previous and the current moved
// edge meet. Coordinates are signed fixed point; the binary point does not
// matter to the arithmetic. Results saturate to the coordinate range, and
// degenerate_o flags a corner whose edges are parallel or of zero length (that
// corner then shows the start of its moved edge). A request is taken at every
// clock edge where start is high; busy stays low, so a new request can follow
// each cycle. Each request gives exactly one result, shown for one cycle with
// done_o high. The result cannot be held off: capture it when done_o is high.
// The pipeline depth is set by the bit-serial stages: the edge length square
// root and the normal divider take one bit per stage, and the intersection
// divider takes 41 stages for its clamped quotient. The block keeps no state
// between requests.
module quad_edge_offset_unit import qeo_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] corner0_x_i,
  input  logic signed [COORD_WIDTH-1:0] corner0_y_i,
  input  logic signed [COORD_WIDTH-1:0] corner1_x_i,
  input  logic signed [COORD_WIDTH-1:0] corner1_y_i,
  input  logic signed [COORD_WIDTH-1:0] corner2_x_i,
  input  logic signed [COORD_WIDTH-1:0] corner2_y_i,
  input  logic signed [COORD_WIDTH-1:0] corner3_x_i,
  input  logic signed [COORD_WIDTH-1:0] corner3_y_i,
  input  logic signed [COORD_WIDTH-1:0] offset_distance_i,
  output logic                          done_o,
  output logic signed [COORD_WIDTH-1:0] out0_x_o,
  output logic signed [COORD_WIDTH-1:0] out0_y_o,
  output logic signed [COORD_WIDTH-1:0] out1_x_o,
  output logic signed [COORD_WIDTH-1:0] out1_y_o,
  output logic signed [COORD_WIDTH-1:0] out2_x_o,
  output logic signed [COORD_WIDTH-1:0] out2_y_o,
  output logic signed [COORD_WIDTH-1:0] out3_x_o,
  output logic signed [COORD_WIDTH-1:0] out3_y_o,
  output logic                          degenerate_o
);

  localparam int W = COORD_WIDTH;

  logic signed [W-1:0] px_w [4];
  logic signed [W-1:0] py_w [4];
  logic signed [W+1:0] bx_w [4];
  logic signed [W+1:0] by_w [4];
  logic signed [W:0]   dx_w [4];
  logic signed [W:0]   dy_w [4];
  logic signed [W-1:0] cx_w [4];
  logic signed [W-1:0] cy_w [4];
  logic [3:0]          evld_w;
  logic [3:0]          cvld_w;
  logic [3:0]          cdeg_w;

  // The pipeline never stalls.
  assign busy = 1'b0;

  assign px_w[0] = corner0_x_i;
  assign py_w[0] = corner0_y_i;
  assign px_w[1] = corner1_x_i;
  assign py_w[1] = corner1_y_i;
  assign px_w[2] = corner2_x_i;
  assign py_w[2] = corner2_y_i;
  assign px_w[3] = corner3_x_i;
  assign py_w[3] = corner3_y_i;

  // Edge k runs from corner k to corner k+1.
  for (genvar k = 0; k < 4; k++) begin : g_edge
    qeo_edge #(
      .COORD_WIDTH (W)
    ) u_edge (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (start),
      .p0x_i   (px_w[k]),
      .p0y_i   (py_w[k]),
      .p1x_i   (px_w[(k+1)%4]),
      .p1y_i   (py_w[(k+1)%4]),
      .dist_i  (offset_distance_i),
      .valid_o (evld_w[k]),
      .bx_o    (bx_w[k]),
      .by_o    (by_w[k]),
      .dx_o    (dx_w[k]),
      .dy_o    (dy_w[k])
    );
  end

  // Corner k meets moved edge k-1 with moved edge k.
  for (genvar k = 0; k < 4; k++) begin : g_corner
    qeo_corner #(
      .COORD_WIDTH (W)
    ) u_corner (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (evld_w[k] & evld_w[(k+3)%4]),
      .bxp_i   (bx_w[(k+3)%4]),
      .byp_i   (by_w[(k+3)%4]),
      .dxp_i   (dx_w[(k+3)%4]),
      .dyp_i   (dy_w[(k+3)%4]),
      .bxk_i   (bx_w[k]),
      .byk_i   (by_w[k]),
      .dxk_i   (dx_w[k]),
      .dyk_i   (dy_w[k]),
      .valid_o (cvld_w[k]),
      .cx_o    (cx_w[k]),
      .cy_o    (cy_w[k]),
      .degen_o (cdeg_w[k])
    );
  end

  // All corners run in lockstep; merge their strobes and flags.
  assign done_o       = &cvld_w;
  assign degenerate_o = |cdeg_w;
  assign out0_x_o     = cx_w[0];
  assign out0_y_o     = cy_w[0];
  assign out1_x_o     = cx_w[1];
  assign out1_y_o     = cy_w[1];
  assign out2_x_o     = cx_w[2];
  assign out2_y_o     = cy_w[2];
  assign out3_x_o     = cx_w[3];
  assign out3_y_o     = cy_w[3];

endmodule
